[sv/pgmap_pkg.sv]
// Shared constants, types and helpers of the four-level page table mapper.
package pgmap_pkg;

   localparam int POOL_PAGES       = 64;
   localparam int TABLE_ENTRIES    = 512;
   localparam int PAGE_OFFSET_BITS = 12;

   localparam int LVL_BITS   = $clog2(TABLE_ENTRIES);
   localparam int PAGE_W     = $clog2(POOL_PAGES);
   localparam int ADDR_W     = PAGE_W + LVL_BITS;
   localparam int MEM_DEPTH  = POOL_PAGES * TABLE_ENTRIES;
   localparam int FFREE_W    = 7;
   localparam int NFREE_W    = ($clog2(POOL_PAGES + 1) > FFREE_W) ?
                               $clog2(POOL_PAGES + 1) : FFREE_W;
   localparam int VA_W       = 48;
   localparam int PA_W       = 52;
   localparam int FRAME_W    = PA_W - PAGE_OFFSET_BITS;
   localparam int FLAG_W     = 12;
   localparam int ENTRY_W    = 64;
   localparam int STATUS_W   = 2;
   localparam int MADE_W     = 2;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = FRAME_W;

   typedef enum logic [STATUS_W-1:0] {
      STAT_DONE      = 2'd0,
      STAT_ABSENT    = 2'd1,
      STAT_EXHAUSTED = 2'd2,
      STAT_OUTSIDE   = 2'd3
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_POOL_BASE  = 1'b0,
      CSR_FIRST_FREE = 1'b1
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ROOT,
      ST_READ,
      ST_EVAL,
      ST_ZERO,
      ST_LINK,
      ST_LEAF,
      ST_FINISH
   } state_type;

   typedef enum logic [2:0] {
      MEM_IDLE,
      MEM_READ,
      MEM_CLEAR,
      MEM_ZERO,
      MEM_LINK,
      MEM_LEAF
   } mem_op_type;

   typedef enum logic [1:0] {
      PG_HOLD,
      PG_ROOT,
      PG_ENTRY,
      PG_ALLOC
   } page_sel_type;

   typedef struct packed {
      logic         load_req;
      logic         cnt_clear;
      mem_op_type   mem_op;
      page_sel_type page_sel;
      logic         lvl_top;
      logic         lvl_dec;
      logic         alloc;
      logic         link_done;
      logic         rsp_load;
      status_type   rsp_status;
   } dp_cmd_type;

   typedef struct packed {
      logic root_ok;
      logic ent_present;
      logic ent_ok;
      logic pool_full;
      logic unmap;
      logic lvl_last;
      logic clear_last;
      logic zero_last;
      logic rsp_busy;
   } dp_stat_type;

   typedef struct packed {
      logic              ok;
      logic [PAGE_W-1:0] page;
   } page_hit_type;

   // Frame number to pool page, with the in-pool check.
   function automatic page_hit_type frame_to_page(input logic [FRAME_W-1:0] frame,
                                                  input logic [FRAME_W-1:0] base);
      logic [FRAME_W-1:0] off;
      page_hit_type       hit;
      off      = frame - base;
      hit.ok   = (frame >= base) && (off < FRAME_W'(POOL_PAGES));
      hit.page = off[PAGE_W-1:0];
      return hit;
   endfunction

endpackage

[sv/pgmap_ifs.sv]
// Request and response channel interfaces of the page table mapper.
interface pgmap_req_if;
   import pgmap_pkg::*;
   logic                valid;
   logic                ready;
   logic                mode;
   logic [VA_W-1:0]     virt_addr;
   logic [PA_W-1:0]     phys_addr;
   logic [FLAG_W-1:0]   attr_flags;
   logic [PA_W-1:0]     root_addr;

   modport source (output valid, mode, virt_addr, phys_addr, attr_flags, root_addr,
                   input ready);
   modport sink   (input valid, mode, virt_addr, phys_addr, attr_flags, root_addr,
                   output ready);
endinterface

interface pgmap_rsp_if;
   import pgmap_pkg::*;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [MADE_W-1:0]   tables_allocated;

   modport source (output valid, status, tables_allocated, input ready);
   modport sink   (input valid, status, tables_allocated, output ready);
endinterface

[sv/pgmap_ctrl.sv]
// Walk controller: sequences clear pass, level reads, page zeroing and writes.
module pgmap_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output pgmap_pkg::dp_cmd_type   cmd,
   input  pgmap_pkg::dp_stat_type  stat
);
   import pgmap_pkg::*;

   state_type  state_ff, state_in;
   status_type status_ff, status_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         status_ff <= STAT_DONE;
      end else begin
         state_ff  <= state_in;
         status_ff <= status_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      status_in      = status_ff;
      req_ready      = 1'b0;
      cmd            = '0;
      cmd.mem_op     = MEM_IDLE;
      cmd.page_sel   = PG_HOLD;
      cmd.rsp_status = status_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.mem_op = MEM_CLEAR;
            if (stat.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_ROOT;
            end
         end
         ST_ROOT: begin
            if (stat.root_ok) begin
               cmd.page_sel = PG_ROOT;
               cmd.lvl_top  = 1'b1;
               state_in     = ST_READ;
            end else begin
               status_in = STAT_OUTSIDE;
               state_in  = ST_FINISH;
            end
         end
         ST_READ: begin
            cmd.mem_op = MEM_READ;
            state_in   = ST_EVAL;
         end
         ST_EVAL: begin
            priority if (stat.ent_present) begin
               if (stat.ent_ok) begin
                  cmd.page_sel = PG_ENTRY;
                  cmd.lvl_dec  = 1'b1;
                  state_in     = stat.lvl_last ? ST_LEAF : ST_READ;
               end else begin
                  status_in = STAT_OUTSIDE;
                  state_in  = ST_FINISH;
               end
            end else if (stat.unmap) begin
               status_in = STAT_ABSENT;
               state_in  = ST_FINISH;
            end else if (stat.pool_full) begin
               status_in = STAT_EXHAUSTED;
               state_in  = ST_FINISH;
            end else begin
               cmd.alloc     = 1'b1;
               cmd.cnt_clear = 1'b1;
               state_in      = ST_ZERO;
            end
         end
         ST_ZERO: begin
            cmd.mem_op = MEM_ZERO;
            if (stat.zero_last) begin
               state_in = ST_LINK;
            end
         end
         ST_LINK: begin
            cmd.mem_op    = MEM_LINK;
            cmd.page_sel  = PG_ALLOC;
            cmd.lvl_dec   = 1'b1;
            cmd.link_done = 1'b1;
            state_in      = stat.lvl_last ? ST_LEAF : ST_READ;
         end
         ST_LEAF: begin
            cmd.mem_op = MEM_LEAF;
            status_in  = STAT_DONE;
            state_in   = ST_FINISH;
         end
         ST_FINISH: begin
            if (!stat.rsp_busy) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

[sv/pgmap_dp.sv]
// Walk datapath: request registers, table memory, allocator and result register.
module pgmap_dp (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_mode,
   input  logic [pgmap_pkg::VA_W-1:0]      req_virt_addr,
   input  logic [pgmap_pkg::PA_W-1:0]      req_phys_addr,
   input  logic [pgmap_pkg::FLAG_W-1:0]    req_attr_flags,
   input  logic [pgmap_pkg::PA_W-1:0]      req_root_addr,
   input  logic                            csr_wr_en,
   input  logic [pgmap_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [pgmap_pkg::CSR_DATA_W-1:0] csr_wr_data,
   input  pgmap_pkg::dp_cmd_type           cmd,
   output pgmap_pkg::dp_stat_type          stat,
   pgmap_rsp_if.source                     rsp_ch
);
   import pgmap_pkg::*;

   logic [ENTRY_W-1:0] mem [MEM_DEPTH];

   logic                mode_ff;
   logic [VA_W-1:0]     va_ff;
   logic [PA_W-1:0]     pa_ff;
   logic [FLAG_W-1:0]   flags_ff;
   logic [PA_W-1:0]     root_ff;
   logic [FRAME_W-1:0]  base_ff;
   logic [NFREE_W-1:0]  next_free_ff;
   logic [PAGE_W-1:0]   alloc_page_ff;
   logic [PAGE_W-1:0]   page_ff, page_in;
   logic [1:0]          lvl_ff;
   logic [MADE_W-1:0]   made_ff;
   logic [ADDR_W-1:0]   cnt_ff;
   logic [ENTRY_W-1:0]  rd_data_ff;
   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [MADE_W-1:0]   rsp_made_ff;

   logic [LVL_BITS-1:0] lvl_idx;
   logic [ADDR_W-1:0]   walk_addr;
   logic [ADDR_W-1:0]   wr_addr;
   logic [ENTRY_W-1:0]  wr_data;
   logic                wr_en;
   logic [FRAME_W-1:0]  link_frame;
   page_hit_type        root_hit, ent_hit;

   // Request and configuration registers
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         mode_ff  <= req_mode;
         va_ff    <= req_virt_addr;
         pa_ff    <= req_phys_addr;
         flags_ff <= req_attr_flags;
         root_ff  <= req_root_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= '0;
         next_free_ff <= NFREE_W'(1);
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_POOL_BASE:  base_ff      <= csr_wr_data;
            CSR_FIRST_FREE: next_free_ff <= NFREE_W'(csr_wr_data[FFREE_W-1:0]);
            default: ;
         endcase
      end else if (cmd.alloc) begin
         next_free_ff <= next_free_ff + NFREE_W'(1);
      end
   end

   // Walk position
   assign root_hit = frame_to_page(root_ff[PA_W-1:PAGE_OFFSET_BITS], base_ff);
   assign ent_hit  = frame_to_page(rd_data_ff[PA_W-1:PAGE_OFFSET_BITS], base_ff);

   always_comb begin
      unique case (cmd.page_sel)
         PG_ROOT:  page_in = root_hit.page;
         PG_ENTRY: page_in = ent_hit.page;
         PG_ALLOC: page_in = alloc_page_ff;
         default:  page_in = page_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      page_ff <= page_in;
      if (cmd.alloc) begin
         alloc_page_ff <= next_free_ff[PAGE_W-1:0];
      end
      if (cmd.lvl_top) begin
         lvl_ff <= 2'd3;
      end else if (cmd.lvl_dec) begin
         lvl_ff <= lvl_ff - 2'd1;
      end
      if (cmd.load_req) begin
         made_ff <= '0;
      end else if (cmd.link_done) begin
         made_ff <= made_ff + MADE_W'(1);
      end
   end

   // Sweep counter for the reset clear pass and for zeroing a new table
   always_ff @(posedge clock) begin
      if (reset || cmd.cnt_clear) begin
         cnt_ff <= '0;
      end else if (cmd.mem_op == MEM_CLEAR || cmd.mem_op == MEM_ZERO) begin
         cnt_ff <= cnt_ff + ADDR_W'(1);
      end
   end

   always_comb begin
      unique case (lvl_ff)
         2'd3:    lvl_idx = va_ff[PAGE_OFFSET_BITS + 3*LVL_BITS +: LVL_BITS];
         2'd2:    lvl_idx = va_ff[PAGE_OFFSET_BITS + 2*LVL_BITS +: LVL_BITS];
         2'd1:    lvl_idx = va_ff[PAGE_OFFSET_BITS + LVL_BITS +: LVL_BITS];
         default: lvl_idx = va_ff[PAGE_OFFSET_BITS +: LVL_BITS];
      endcase
   end

   assign walk_addr  = {page_ff, lvl_idx};
   assign link_frame = base_ff + FRAME_W'(alloc_page_ff);

   // Memory write side
   always_comb begin
      wr_en   = 1'b1;
      wr_addr = walk_addr;
      wr_data = '0;
      unique case (cmd.mem_op)
         MEM_CLEAR: wr_addr = cnt_ff;
         MEM_ZERO:  wr_addr = {alloc_page_ff, cnt_ff[LVL_BITS-1:0]};
         MEM_LINK:  wr_data = {(ENTRY_W-PA_W)'(0), link_frame, (PAGE_OFFSET_BITS-3)'(0),
                               flags_ff[2], 2'b11};
         MEM_LEAF:  wr_data = mode_ff ? '0 :
                              {(ENTRY_W-PA_W)'(0), pa_ff[PA_W-1:PAGE_OFFSET_BITS],
                               flags_ff | FLAG_W'(1)};
         default:   wr_en = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_op == MEM_READ) begin
         rd_data_ff <= mem[walk_addr];
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_status_ff <= cmd.rsp_status;
         rsp_made_ff   <= made_ff;
      end
   end

   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.status           = rsp_status_ff;
   assign rsp_ch.tables_allocated = rsp_made_ff;

   // Status back to the controller
   assign stat.root_ok     = root_hit.ok;
   assign stat.ent_present = rd_data_ff[0];
   assign stat.ent_ok      = ent_hit.ok;
   assign stat.pool_full   = next_free_ff >= NFREE_W'(POOL_PAGES);
   assign stat.unmap       = mode_ff;
   assign stat.lvl_last    = (lvl_ff == 2'd1);
   assign stat.clear_last  = (cnt_ff == ADDR_W'(MEM_DEPTH - 1));
   assign stat.zero_last   = &cnt_ff[LVL_BITS-1:0];
   assign stat.rsp_busy    = rsp_valid_ff && !rsp_ch.ready;

endmodule

[sv/four_level_page_table_mapper.sv]
// A map/unmap word with every level present runs the root check, then a read and evaluate
// step at each of the three upper levels, then the leaf write and the result load. Each
// missing level on a map adds the zeroing of the new table's 512 entries, then the link
// write; the worst case makes three new tables. The block takes one word at a time.
// Reset: synchronous; afterwards a clear pass writes all POOL_PAGES*512 entries (32768 at
// 64 pages) before the first request word is taken. CSR writes are taken anytime.
module four_level_page_table_mapper (
   input  logic                             clock,
   input  logic                             reset,
   pgmap_req_if.sink                        req_ch,
   pgmap_rsp_if.source                      rsp_ch,
   input  logic                             csr_wr_en,
   input  logic [pgmap_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pgmap_pkg::CSR_DATA_W-1:0] csr_wr_data
);
   import pgmap_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;
   logic        ctrl_ready;

   // Controller owns the request handshake; the datapath latches the word.
   pgmap_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (ctrl_ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   assign req_ch.ready = ctrl_ready;

   // Datapath holds the table memory, allocator and the response register.
   pgmap_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_mode       (req_ch.mode),
      .req_virt_addr  (req_ch.virt_addr),
      .req_phys_addr  (req_ch.phys_addr),
      .req_attr_flags (req_ch.attr_flags),
      .req_root_addr  (req_ch.root_addr),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wr_data    (csr_wr_data),
      .cmd            (cmd),
      .stat           (stat),
      .rsp_ch         (rsp_ch)
   );

endmodule

[verif/tb_four_level_page_table_mapper.sv]
// Self-checking testbench for the four-level page table mapper.
`timescale 1ns / 100ps

module tb_four_level_page_table_mapper;
   import pgmap_pkg::*;

   // Request mode bit and entry bits as the table walk sees them.
   localparam logic MODE_MAP   = 1'b0;
   localparam logic MODE_UNMAP = 1'b1;
   localparam logic [ENTRY_W-1:0] ENTRY_PRESENT  = 64'h1;
   localparam logic [ENTRY_W-1:0] ENTRY_WRITABLE = 64'h2;
   localparam logic [ENTRY_W-1:0] ENTRY_USER     = 64'h4;

   localparam int RANDOM_PHASES   = 8;
   localparam int WORDS_PER_PHASE = 45;

   typedef struct packed {
      logic              mode;
      logic [VA_W-1:0]   va;
      logic [PA_W-1:0]   pa;
      logic [FLAG_W-1:0] flags;
      logic [PA_W-1:0]   root;
   } map_request_type;

   typedef struct packed {
      status_type        status;
      logic [MADE_W-1:0] made;
   } walk_result_type;

   // Directed plan: either a register load or one request word.
   typedef enum logic {ROW_REGS, ROW_WORD} row_kind_type;

   typedef struct {
      row_kind_type         kind;
      logic [FRAME_W-1:0]   base;
      logic [FFREE_W-1:0]   ffree;
      map_request_type      rq;
      bit                   typed;
      walk_result_type      want;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;

   pgmap_req_if req_ch ();
   pgmap_rsp_if rsp_ch ();

   four_level_page_table_mapper dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   // Shadow of the table memory, the bump allocator and the pool registers.
   logic [ENTRY_W-1:0] tbl_mem [MEM_DEPTH];
   logic [FRAME_W-1:0] base_frame;
   logic [FFREE_W-1:0] first_free;
   int                 next_page;

   walk_result_type  expected_outcomes[$];
   walk_result_type  head_outcome;
   directed_row_type plan[$];
   logic [VA_W-1:0] recent_va[$];
   int  mismatch_count = 0;
   int  rsp_word_count = 0;
   bit  idle_on = 1'b1;

   // Physical address to pool page; 0 when the frame falls outside the pool.
   function automatic bit pool_page_of(input logic [PA_W-1:0] addr, output int page);
      logic [FRAME_W-1:0] frame;
      logic [FRAME_W-1:0] off;
      page  = 0;
      frame = addr[PA_W-1:PAGE_OFFSET_BITS];
      if (frame < base_frame) return 1'b0;
      off = frame - base_frame;
      if (off >= FRAME_W'(POOL_PAGES)) return 1'b0;
      page = int'(off);
      return 1'b1;
   endfunction

   // Walk L4..L2 for one request, allocating on map; then write or clear the leaf.
   function automatic walk_result_type walk_tables(input map_request_type rq);
      walk_result_type    res;
      int                 page;
      int                 np;
      int                 lvl;
      int                 k;
      int                 slot_at;
      logic [ENTRY_W-1:0] ent;
      logic [FRAME_W-1:0] nf;
      res.status = STAT_DONE;
      res.made   = '0;
      page       = 0;
      if (!pool_page_of(rq.root, page)) res.status = STAT_OUTSIDE;
      for (lvl = 3; lvl >= 1 && res.status == STAT_DONE; lvl--) begin
         slot_at = page * TABLE_ENTRIES +
                   int'(rq.va[PAGE_OFFSET_BITS + LVL_BITS*lvl +: LVL_BITS]);
         ent = tbl_mem[slot_at];
         if (ent[0]) begin
            if (!pool_page_of(ent[PA_W-1:0], page)) res.status = STAT_OUTSIDE;
         end else if (rq.mode == MODE_UNMAP) begin
            res.status = STAT_ABSENT;
         end else if (next_page >= POOL_PAGES) begin
            res.status = STAT_EXHAUSTED;
         end else begin
            np        = next_page;
            next_page = next_page + 1;
            for (k = 0; k < TABLE_ENTRIES; k++) tbl_mem[np*TABLE_ENTRIES + k] = '0;
            // link frame wraps at 40 bits when the pool sits at the top
            nf = base_frame + FRAME_W'(np);
            tbl_mem[slot_at] = {12'h0, nf, 12'h0} | ENTRY_PRESENT | ENTRY_WRITABLE |
                               (ENTRY_W'(rq.flags) & ENTRY_USER);
            res.made = res.made + MADE_W'(1);
            page     = np;
         end
      end
      if (res.status == STAT_DONE) begin
         slot_at = page * TABLE_ENTRIES + int'(rq.va[PAGE_OFFSET_BITS +: LVL_BITS]);
         if (rq.mode == MODE_UNMAP)
            tbl_mem[slot_at] = '0;
         else
            tbl_mem[slot_at] = {12'h0, rq.pa[PA_W-1:PAGE_OFFSET_BITS], 12'h0} |
                               ENTRY_W'(rq.flags) | ENTRY_PRESENT;
      end
      return res;
   endfunction

   function automatic void add_regs(input logic [FRAME_W-1:0] base,
                                    input logic [FFREE_W-1:0] ffree);
      directed_row_type r;
      r.kind  = ROW_REGS;
      r.base  = base;
      r.ffree = ffree;
      r.rq    = '0;
      r.typed = 1'b0;
      r.want  = '0;
      plan.push_back(r);
   endfunction

   function automatic void add_word(input logic mode, input logic [VA_W-1:0] va,
                                    input logic [PA_W-1:0] pa,
                                    input logic [FLAG_W-1:0] flags,
                                    input logic [PA_W-1:0] root, input bit typed,
                                    input status_type st, input logic [MADE_W-1:0] made);
      directed_row_type r;
      r.kind        = ROW_WORD;
      r.base        = '0;
      r.ffree       = '0;
      r.rq.mode     = mode;
      r.rq.va       = va;
      r.rq.pa       = pa;
      r.rq.flags    = flags;
      r.rq.root     = root;
      r.typed       = typed;
      r.want.status = st;
      r.want.made   = made;
      plan.push_back(r);
   endfunction

   // Drive one request word, hold until taken, then queue its outcome.
   // A typed row overrides the outcome but still advances the shadow state.
   task automatic send_word(input map_request_type rq, input bit typed,
                            input walk_result_type want);
      walk_result_type res;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.mode       <= rq.mode;
      req_ch.virt_addr  <= rq.va;
      req_ch.phys_addr  <= rq.pa;
      req_ch.attr_flags <= rq.flags;
      req_ch.root_addr  <= rq.root;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      res = walk_tables(rq);
      if (typed) res = want;
      expected_outcomes.push_back(res);
   endtask

   // Registers change only with the block idle: drop valid, drain, then write both.
   task automatic load_pool_regs(input logic [FRAME_W-1:0] base,
                                 input logic [FFREE_W-1:0] ffree);
      req_ch.valid <= 1'b0;
      while (expected_outcomes.size() != 0) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_POOL_BASE;
      csr_wr_data <= base;
      @(posedge clock);
      csr_index   <= CSR_FIRST_FREE;
      csr_wr_data <= CSR_DATA_W'(ffree);
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      base_frame = base;
      first_free = ffree;
      next_page  = int'(ffree);
   endtask

   // Mostly walks through a known root with reused or related addresses,
   // so that hits, remaps and unmaps of live leaves are common; the rest is noise.
   task automatic random_words(input int count);
      map_request_type rq;
      walk_result_type none;
      int i;
      int r;
      int page;
      none = '0;
      for (i = 0; i < count; i++) begin
         rq.mode = ($urandom_range(0, 99) < 65) ? MODE_MAP : MODE_UNMAP;
         r = $urandom_range(0, 99);
         if (recent_va.size() != 0 && r < 50) begin
            rq.va = recent_va[$urandom_range(0, recent_va.size() - 1)];
         end else if (recent_va.size() != 0 && r < 75) begin
            // keep the upper levels, new lower indices
            rq.va = recent_va[$urandom_range(0, recent_va.size() - 1)];
            if ($urandom_range(0, 1) == 0)
               rq.va[20:0] = 21'($urandom);
            else
               rq.va[29:0] = 30'($urandom);
            recent_va.push_back(rq.va);
         end else begin
            rq.va = VA_W'({$urandom, $urandom});
            recent_va.push_back(rq.va);
         end
         if (recent_va.size() > 16) void'(recent_va.pop_front());
         rq.va[PAGE_OFFSET_BITS-1:0] = PAGE_OFFSET_BITS'($urandom);
         rq.pa    = PA_W'({$urandom, $urandom});
         rq.flags = FLAG_W'($urandom);
         r = $urandom_range(0, 99);
         if (r < 85) begin
            page    = (r < 60) ? 0 : $urandom_range(0, POOL_PAGES - 1);
            rq.root = {base_frame + FRAME_W'(page), PAGE_OFFSET_BITS'($urandom)};
         end else begin
            rq.root = PA_W'({$urandom, $urandom});
         end
         send_word(rq, 1'b0, none);
      end
   endtask

   // Response side: random stall bursts while idling is on.
   initial begin
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (idle_on && $urandom_range(0, 4) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   end

   // Compare every taken result word against the oldest outcome.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         rsp_word_count <= rsp_word_count + 1;
         if (expected_outcomes.size() == 0) begin
            mismatch_count = mismatch_count + 1;
            if (mismatch_count <= 10)
               $display("unexpected result word %0d: status %0d tables %0d",
                        rsp_word_count, rsp_ch.status, rsp_ch.tables_allocated);
         end else begin
            head_outcome = expected_outcomes.pop_front();
            if (rsp_ch.status !== head_outcome.status ||
                rsp_ch.tables_allocated !== head_outcome.made) begin
               mismatch_count = mismatch_count + 1;
               if (mismatch_count <= 10)
                  $display("result word %0d: status exp %0d got %0d, tables exp %0d got %0d",
                           rsp_word_count, head_outcome.status, rsp_ch.status,
                           head_outcome.made, rsp_ch.tables_allocated);
            end
         end
      end
   end

   // Hard stop, well past the slowest legal run including the post-reset clear.
   initial begin
      #40_000_000;
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      int i;
      int p;
      logic [FRAME_W-1:0] ph_base;
      logic [FFREE_W-1:0] ph_ffree;

      reset             <= 1'b1;
      csr_wr_en         <= 1'b0;
      csr_index         <= CSR_POOL_BASE;
      csr_wr_data       <= '0;
      req_ch.valid      <= 1'b0;
      req_ch.mode       <= MODE_MAP;
      req_ch.virt_addr  <= '0;
      req_ch.phys_addr  <= '0;
      req_ch.attr_flags <= '0;
      req_ch.root_addr  <= '0;

      for (i = 0; i < MEM_DEPTH; i++) tbl_mem[i] = '0;
      base_frame = '0;
      first_free = FFREE_W'(1);
      next_page  = 1;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Reset values: base 0, allocator from page 1. Fresh walk takes pages 1..3.
      add_word(MODE_MAP, 48'h0, 52'h0, 12'h000, 52'h0, 1, STAT_DONE, 2'd3);
      add_word(MODE_MAP, 48'h0, {PA_W{1'b1}}, 12'hFFF, 52'h0, 1, STAT_DONE, 2'd0);
      add_word(MODE_UNMAP, {VA_W{1'b1}}, 52'h0, 12'h000, 52'h0, 1, STAT_ABSENT, 2'd0);
      // ignored root offset bits all set, user bit inherited by the new links
      add_word(MODE_MAP, {VA_W{1'b1}}, {PA_W{1'b1}}, 12'hFFF, 52'hFFF, 1, STAT_DONE, 2'd3);
      add_word(MODE_UNMAP, {VA_W{1'b1}}, 52'h0, 12'h000, 52'h0, 1, STAT_DONE, 2'd0);
      // second unmap: levels stay present, leaf already clear
      add_word(MODE_UNMAP, {VA_W{1'b1}}, 52'h0, 12'h000, 52'h0, 1, STAT_DONE, 2'd0);
      // root one page past the pool, and the very top of the address space
      add_word(MODE_MAP, 48'h0, 52'h0, 12'h000, 52'h40000, 1, STAT_OUTSIDE, 2'd0);
      add_word(MODE_UNMAP, 48'h0, 52'h0, 12'h000, {PA_W{1'b1}}, 1, STAT_OUTSIDE, 2'd0);
      // leaf table used as root: its present leaf points outside the pool
      add_word(MODE_MAP, 48'h0, 52'h0, 12'h000, 52'h3000, 0, STAT_DONE, 2'd0);
      add_word(MODE_MAP, 48'h0000_4000_0000, 52'h5_5555_5555_5555, 12'h004, 52'h0,
               0, STAT_DONE, 2'd0);
      add_word(MODE_MAP, 48'h0000_0020_0000, 52'hA_AAAA_AAAA_AAAA, 12'h002, 52'h0,
               0, STAT_DONE, 2'd0);
      add_word(MODE_UNMAP, 48'h0000_4000_0FFF, 52'h0, 12'h000, 52'h0, 0, STAT_DONE, 2'd0);
      // One page left: L3 gets page 63, L2 runs dry.
      add_regs(40'h0, 7'd63);
      add_word(MODE_MAP, 48'h0280_0000_0000, 52'h1000, 12'h001, 52'h0,
               1, STAT_EXHAUSTED, 2'd1);
      add_word(MODE_MAP, 48'h0280_0000_0000, 52'h1000, 12'h001, 52'h0,
               1, STAT_EXHAUSTED, 2'd0);
      add_word(MODE_UNMAP, 48'h0280_0000_0000, 52'h0, 12'h000, 52'h0, 1, STAT_ABSENT, 2'd0);
      add_word(MODE_MAP, 48'h0, 52'hA_BCDE_F012_3456, 12'h7FF, 52'h0, 1, STAT_DONE, 2'd0);
      // Pool at the top frame, allocator from page 0: root zeroes itself, later
      // links wrap to low frames and read back as outside the pool.
      add_regs({FRAME_W{1'b1}}, 7'd0);
      add_word(MODE_MAP, 48'h8000_0000_0000, 52'h2000, 12'h006, 52'hF_FFFF_FFFF_F000,
               0, STAT_DONE, 2'd0);
      add_word(MODE_MAP, 48'h8000_0000_0000, 52'h2000, 12'h006, 52'hF_FFFF_FFFF_F000,
               0, STAT_DONE, 2'd0);
      add_word(MODE_UNMAP, 48'h8000_0000_0000, 52'h0, 12'h000, 52'hF_FFFF_FFFF_F000,
               0, STAT_DONE, 2'd0);
      add_word(MODE_MAP, {VA_W{1'b1}}, 52'h0, 12'hFFB, {PA_W{1'b1}}, 0, STAT_DONE, 2'd0);
      // Highest base where the whole pool fits, allocator already empty.
      add_regs(40'hFF_FFFF_FFC0, 7'd64);
      add_word(MODE_MAP, 48'h1234_5678_9000, 52'h3000, 12'h000, 52'hF_FFFF_FFC0_0000,
               0, STAT_DONE, 2'd0);
      add_word(MODE_UNMAP, 48'h1234_5678_9000, 52'h0, 12'h000, 52'hF_FFFF_FFFF_F000,
               0, STAT_DONE, 2'd0);

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_REGS)
            load_pool_regs(plan[i].base, plan[i].ffree);
         else
            send_word(plan[i].rq, plan[i].typed, plan[i].want);
      end

      // Random phases, each under its own pool setting; the last runs without idling.
      for (p = 0; p < RANDOM_PHASES; p++) begin
         unique case (p)
            0:       begin ph_base = '0;                          ph_ffree = 7'd1;  end
            1:       begin ph_base = FRAME_W'({$urandom, $urandom});
                           ph_ffree = FFREE_W'($urandom_range(0, 8));           end
            2:       begin ph_base = base_frame;                  ph_ffree = 7'd40; end
            3:       begin ph_base = 40'hFF_FFFF_FFC0;            ph_ffree = 7'd64; end
            4:       begin ph_base = FRAME_W'({$urandom, $urandom}); ph_ffree = 7'd1; end
            5:       begin ph_base = base_frame;                  ph_ffree = 7'd32; end
            6:       begin ph_base = {FRAME_W{1'b1}};             ph_ffree = 7'd1;  end
            default: begin ph_base = '0;                          ph_ffree = 7'd2;  end
         endcase
         load_pool_regs(ph_base, ph_ffree);
         idle_on = (p != RANDOM_PHASES - 1);
         random_words(WORDS_PER_PHASE);
      end

      req_ch.valid <= 1'b0;
      while (expected_outcomes.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      if (mismatch_count == 0 && expected_outcomes.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
